>>> rtl/position_verlet_vector_step_macros.svh
// assertion macros for the position verlet vector step block
`ifndef POSITION_VERLET_VECTOR_STEP_MACROS_SVH
`define POSITION_VERLET_VECTOR_STEP_MACROS_SVH

// same-cycle implication, checked at every rising edge out of reset
`define PVS_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pvs check failed: same-cycle implication");

// next-cycle implication, checked at every rising edge out of reset
`define PVS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pvs check failed: next-cycle implication");

`endif

>>> rtl/pvs_pkg.sv
// shared types and constants of the position verlet vector step block
`default_nettype none

package pvs_pkg;

    // vector and value geometry
    localparam int MAX_ELEMENTS = 64;
    localparam int ADDR_W       = $clog2(MAX_ELEMENTS);
    localparam int INDEX_W      = 6;
    localparam int STAGE_W      = 2;
    localparam int VALUE_W      = 48;
    localparam int STEP_W       = 32;

    // product scaling: full step drops 16 fraction bits, half step 17
    localparam int SHIFT_FULL = 16;
    localparam int SHIFT_HALF = 17;

    // stage codes
    localparam logic [STAGE_W-1:0] STAGE_HALF = STAGE_W'(1);
    localparam logic [STAGE_W-1:0] STAGE_FULL = STAGE_W'(2);

    // time step after reset is 1.0 in Q16.16
    localparam logic [STEP_W-1:0] TIME_STEP_RESET = STEP_W'(65536);

    // saturation limits
    localparam logic [VALUE_W-1:0] VALUE_MAX = {1'b0, {(VALUE_W-1){1'b1}}};
    localparam logic [VALUE_W-1:0] VALUE_MIN = {1'b1, {(VALUE_W-1){1'b0}}};

    typedef logic signed [VALUE_W-1:0] t_value;

    // request to and response from the multiply unit
    typedef struct packed {
        logic start;
        logic half;
    } t_mul_req;

    typedef struct packed {
        logic done;
        logic ov;
    } t_mul_rsp;

endpackage

`default_nettype wire

>>> rtl/pvs_if.sv
// handshake interfaces for item input, result output and configuration
`default_nettype none

interface pvs_in_if;
    logic                          valid;
    logic                          ready;
    logic [pvs_pkg::STAGE_W-1:0]   stage;
    logic [pvs_pkg::INDEX_W-1:0]   element_index;
    logic                          last_element;
    logic                          restart_request;
    pvs_pkg::t_value               acceleration;
    pvs_pkg::t_value               velocity_in;
    pvs_pkg::t_value               position_in;

    modport source (
        output valid, stage, element_index, last_element, restart_request,
               acceleration, velocity_in, position_in,
        input  ready
    );
    modport sink (
        input  valid, stage, element_index, last_element, restart_request,
               acceleration, velocity_in, position_in,
        output ready
    );
endinterface

interface pvs_out_if;
    logic            valid;
    logic            ready;
    pvs_pkg::t_value position_out;
    pvs_pkg::t_value velocity_out;
    logic            half_step;
    logic            overflow;
    logic            last_out;

    modport source (
        output valid, position_out, velocity_out, half_step, overflow, last_out,
        input  ready
    );
    modport sink (
        input  valid, position_out, velocity_out, half_step, overflow, last_out,
        output ready
    );
endinterface

interface pvs_cfg_if;
    logic                       valid;
    logic                       ready;
    logic [pvs_pkg::STEP_W-1:0] time_step;

    modport source (
        output valid, time_step,
        input  ready
    );
    modport sink (
        input  valid, time_step,
        output ready
    );
endinterface

`default_nettype wire

>>> rtl/pvs_ram.sv
// generic single-write, single-read synchronous ram with registered read data
`default_nettype none

module pvs_ram #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 48
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // read port, read data registered while read enable is high
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

>>> rtl/pvs_mulsat.sv
// multi-cycle value times time step, truncated toward zero and saturated
`default_nettype none

module pvs_mulsat (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire pvs_pkg::t_mul_req          i_req,
    input  wire pvs_pkg::t_value            i_operand,
    input  wire logic [pvs_pkg::STEP_W-1:0] i_step,
    output pvs_pkg::t_mul_rsp               o_rsp,
    output pvs_pkg::t_value                 o_product
);

    localparam int LO_W   = pvs_pkg::VALUE_W / 2;
    localparam int HI_W   = pvs_pkg::VALUE_W - LO_W;
    localparam int PP_W   = HI_W + pvs_pkg::STEP_W;
    localparam int PROD_W = pvs_pkg::VALUE_W + pvs_pkg::STEP_W;

    typedef enum logic [2:0] {
        M_IDLE,
        M_LO,
        M_HI,
        M_SUM,
        M_SAT
    } t_mstate;

    t_mstate                      r_mstate;
    logic                         r_neg;
    logic                         r_half;
    logic [pvs_pkg::VALUE_W-1:0]  r_mag;
    logic [PP_W-1:0]              r_plo;
    logic [PP_W-1:0]              r_phi;
    logic [PROD_W-1:0]            r_sum;
    logic                         r_done;
    logic                         r_ov;
    pvs_pkg::t_value              r_product;

    logic [pvs_pkg::VALUE_W-1:0]  w_abs;
    logic [HI_W-1:0]              w_mul_a;
    logic [PP_W-1:0]              w_mul_p;
    logic [PROD_W-1:0]            w_q;
    logic [PROD_W-1:0]            w_lim;
    logic                         w_sat;
    logic [pvs_pkg::VALUE_W-1:0]  w_qv;
    logic [pvs_pkg::VALUE_W-1:0]  w_res;

    // magnitude of the incoming operand
    assign w_abs = i_operand[pvs_pkg::VALUE_W-1]
                 ? (~pvs_pkg::VALUE_W'(i_operand)) + pvs_pkg::VALUE_W'(1)
                 : pvs_pkg::VALUE_W'(i_operand);

    // one shared partial-product multiplier: low half, then high half
    assign w_mul_a = (r_mstate == M_LO) ? HI_W'(r_mag[LO_W-1:0])
                                         : r_mag[pvs_pkg::VALUE_W-1:LO_W];
    assign w_mul_p = PP_W'(w_mul_a) * PP_W'(i_step);

    // scale, compare against the signed limit, restore the sign
    assign w_q   = r_half ? (r_sum >> pvs_pkg::SHIFT_HALF)
                          : (r_sum >> pvs_pkg::SHIFT_FULL);
    assign w_lim = PROD_W'(pvs_pkg::VALUE_MAX) + PROD_W'(r_neg);
    assign w_sat = (w_q > w_lim);
    assign w_qv  = w_q[pvs_pkg::VALUE_W-1:0];

    always_comb begin
        if (w_sat) begin
            w_res = r_neg ? pvs_pkg::VALUE_MIN : pvs_pkg::VALUE_MAX;
        end else if (r_neg) begin
            w_res = (~w_qv) + pvs_pkg::VALUE_W'(1);
        end else begin
            w_res = w_qv;
        end
    end

    // sequencer and datapath registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mstate <= M_IDLE;
            r_done   <= 1'b0;
        end else begin
            r_done <= 1'b0;
            unique case (r_mstate)
                M_IDLE: begin
                    if (i_req.start) begin
                        r_mag    <= w_abs;
                        r_neg    <= i_operand[pvs_pkg::VALUE_W-1];
                        r_half   <= i_req.half;
                        r_mstate <= M_LO;
                    end
                end
                M_LO: begin
                    r_plo    <= w_mul_p;
                    r_mstate <= M_HI;
                end
                M_HI: begin
                    r_phi    <= w_mul_p;
                    r_mstate <= M_SUM;
                end
                M_SUM: begin
                    r_sum    <= {r_phi, {LO_W{1'b0}}} + PROD_W'(r_plo);
                    r_mstate <= M_SAT;
                end
                M_SAT: begin
                    r_product <= pvs_pkg::t_value'(w_res);
                    r_ov      <= w_sat;
                    r_done    <= 1'b1;
                    r_mstate  <= M_IDLE;
                end
                default: begin
                    r_mstate <= M_IDLE;
                end
            endcase
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.ov   = r_ov;
    assign o_product  = r_product;

endmodule

`default_nettype wire

>>> rtl/position_verlet_vector_step.sv
// A stage 1 or stage 2 item reads the saved-velocity and saved-acceleration memories, then
// runs the shared multiply unit twice before its result is loaded into the output register;
// a pass-through item goes straight to the output register. The next item is taken only
// after the current one is loaded, so a stalled sink that holds the output register holds it.
// Reset (synchronous, active low): time step 1.0, restart pending set, output empty.
`default_nettype none
`include "position_verlet_vector_step_macros.svh"

module position_verlet_vector_step (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    pvs_in_if.sink     i_in,
    pvs_out_if.source  o_out,
    pvs_cfg_if.sink    i_cfg
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_MUL1,
        S_START2,
        S_MUL2,
        S_OUT
    } t_state;

    t_state                       r_state;
    logic [pvs_pkg::STEP_W-1:0]   r_time_step;
    logic                         r_restart;
    logic                         r_use_acc;
    logic [pvs_pkg::STAGE_W-1:0]  r_stage;
    logic                         r_last;
    logic                         r_ov;
    pvs_pkg::t_value              r_pos;
    pvs_pkg::t_value              r_vel;
    pvs_pkg::t_value              r_acc;

    logic                         r_out_valid;
    pvs_pkg::t_value              r_out_pos;
    pvs_pkg::t_value              r_out_vel;
    logic                         r_out_half;
    logic                         r_out_ov;
    logic                         r_out_last;

    logic                         w_in_acc;
    logic                         w_in_half;
    logic                         w_in_full;
    logic [pvs_pkg::ADDR_W-1:0]   w_addr;
    logic [pvs_pkg::VALUE_W-1:0]  w_sv_rdata;
    logic [pvs_pkg::VALUE_W-1:0]  w_sa_rdata;
    logic                         w_is_half;
    logic                         w_to_pos;
    pvs_pkg::t_mul_req            w_mul_req;
    pvs_pkg::t_mul_rsp            w_mul_rsp;
    pvs_pkg::t_value              w_operand;
    pvs_pkg::t_value              w_product;
    pvs_pkg::t_value              w_addend;
    logic [pvs_pkg::VALUE_W:0]    w_add;
    logic                         w_pass_end;
    logic                         w_restart_req;
    logic                         w_mul_wait;
    logic                         w_out_blocked;

    // saturating add: top bit flags overflow
    function automatic logic [pvs_pkg::VALUE_W:0] sat_add(
        input pvs_pkg::t_value a,
        input pvs_pkg::t_value b
    );
        logic [pvs_pkg::VALUE_W:0] s;
        s = {a[pvs_pkg::VALUE_W-1], a} + {b[pvs_pkg::VALUE_W-1], b};
        if (s[pvs_pkg::VALUE_W] != s[pvs_pkg::VALUE_W-1]) begin
            return {1'b1, s[pvs_pkg::VALUE_W] ? pvs_pkg::VALUE_MIN : pvs_pkg::VALUE_MAX};
        end
        return {1'b0, s[pvs_pkg::VALUE_W-1:0]};
    endfunction

    // handshakes
    assign i_in.ready  = (r_state == S_IDLE);
    assign i_cfg.ready = 1'b1;
    assign w_in_acc    = i_in.valid && i_in.ready;
    assign w_in_half   = (i_in.stage == pvs_pkg::STAGE_HALF);
    assign w_in_full   = (i_in.stage == pvs_pkg::STAGE_FULL);
    assign w_addr      = i_in.element_index[pvs_pkg::ADDR_W-1:0];

    // time step register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_time_step <= pvs_pkg::TIME_STEP_RESET;
        end else if (i_cfg.valid && i_cfg.ready) begin
            r_time_step <= i_cfg.time_step;
        end
    end

    // saved velocity: written by half-step items, read by full-step items
    pvs_ram #(
        .DEPTH (pvs_pkg::MAX_ELEMENTS),
        .WIDTH (pvs_pkg::VALUE_W)
    ) u_vel_mem (
        .i_clk   (i_clk),
        .i_we    (w_in_acc && w_in_half),
        .i_waddr (w_addr),
        .i_wdata (pvs_pkg::VALUE_W'(i_in.velocity_in)),
        .i_re    (w_in_acc),
        .i_raddr (w_addr),
        .o_rdata (w_sv_rdata)
    );

    // saved acceleration: written by full-step items, read by half-step items
    pvs_ram #(
        .DEPTH (pvs_pkg::MAX_ELEMENTS),
        .WIDTH (pvs_pkg::VALUE_W)
    ) u_accel_mem (
        .i_clk   (i_clk),
        .i_we    (w_in_acc && w_in_full),
        .i_waddr (w_addr),
        .i_wdata (pvs_pkg::VALUE_W'(i_in.acceleration)),
        .i_re    (w_in_acc),
        .i_raddr (w_addr),
        .o_rdata (w_sa_rdata)
    );

    // multiply requests: first product uses velocity (half) or acceleration (full),
    // second uses acceleration (half) or the new velocity (full)
    assign w_is_half       = (r_stage == pvs_pkg::STAGE_HALF);
    assign w_mul_req.start = (r_state == S_READ) || (r_state == S_START2);
    assign w_mul_req.half  = (r_state == S_START2) || w_is_half;
    assign w_operand       = ((r_state == S_READ) == w_is_half) ? r_vel : r_acc;

    pvs_mulsat u_mulsat (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_req     (w_mul_req),
        .i_operand (w_operand),
        .i_step    (r_time_step),
        .o_rsp     (w_mul_rsp),
        .o_product (w_product)
    );

    // accumulate into position or velocity depending on pass and stage
    assign w_to_pos = ((r_state == S_MUL1) == w_is_half);
    assign w_addend = w_to_pos ? r_pos : r_vel;
    assign w_add    = sat_add(w_addend, w_product);

    // item sequencer and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_restart   <= 1'b1;
            r_out_valid <= 1'b0;
        end else begin
            // result register: load a finished item, drop it once taken
            if ((r_state == S_OUT) && (!r_out_valid || o_out.ready)) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (w_in_acc) begin
                        r_stage   <= i_in.stage;
                        r_last    <= i_in.last_element;
                        r_pos     <= i_in.position_in;
                        r_vel     <= i_in.velocity_in;
                        r_acc     <= i_in.acceleration;
                        r_ov      <= 1'b0;
                        r_use_acc <= r_restart || i_in.restart_request;
                        if (w_in_half && i_in.last_element) begin
                            r_restart <= 1'b0;
                        end else if (i_in.restart_request) begin
                            r_restart <= 1'b1;
                        end
                        r_state <= (w_in_half || w_in_full) ? S_READ : S_OUT;
                    end
                end
                S_READ: begin
                    if (w_is_half && !r_use_acc) begin
                        r_acc <= pvs_pkg::t_value'(w_sa_rdata);
                    end
                    if (!w_is_half) begin
                        r_vel <= pvs_pkg::t_value'(w_sv_rdata);
                    end
                    r_state <= S_MUL1;
                end
                S_MUL1: begin
                    if (w_mul_rsp.done) begin
                        if (w_to_pos) begin
                            r_pos <= pvs_pkg::t_value'(w_add[pvs_pkg::VALUE_W-1:0]);
                        end else begin
                            r_vel <= pvs_pkg::t_value'(w_add[pvs_pkg::VALUE_W-1:0]);
                        end
                        r_ov    <= r_ov || w_mul_rsp.ov || w_add[pvs_pkg::VALUE_W];
                        r_state <= S_START2;
                    end
                end
                S_START2: begin
                    r_state <= S_MUL2;
                end
                S_MUL2: begin
                    if (w_mul_rsp.done) begin
                        if (w_to_pos) begin
                            r_pos <= pvs_pkg::t_value'(w_add[pvs_pkg::VALUE_W-1:0]);
                        end else begin
                            r_vel <= pvs_pkg::t_value'(w_add[pvs_pkg::VALUE_W-1:0]);
                        end
                        r_ov    <= r_ov || w_mul_rsp.ov || w_add[pvs_pkg::VALUE_W];
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (!r_out_valid || o_out.ready) begin
                        r_out_pos   <= r_pos;
                        r_out_vel   <= r_vel;
                        r_out_half  <= w_is_half;
                        r_out_ov    <= r_ov;
                        r_out_last  <= r_last;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // result channel
    assign o_out.valid        = r_out_valid;
    assign o_out.position_out = r_out_pos;
    assign o_out.velocity_out = r_out_vel;
    assign o_out.half_step    = r_out_half;
    assign o_out.overflow     = r_out_ov;
    assign o_out.last_out     = r_out_last;

    // terms watched by the checks below
    assign w_pass_end    = w_in_acc && w_in_half && i_in.last_element;
    assign w_restart_req = w_in_acc && i_in.restart_request;
    assign w_mul_wait    = (r_state == S_MUL1) || (r_state == S_MUL2);
    assign w_out_blocked = (r_state == S_OUT) && r_out_valid && !o_out.ready;

    // a product only comes back while the sequencer waits for one
    `PVS_ASSERT_NOW(a_mul_done_waited, i_clk, i_rst_n, w_mul_rsp.done, w_mul_wait)

    // the last half-step item of a pass clears the restart flag
    `PVS_ASSERT_NEXT(a_restart_clears, i_clk, i_rst_n, w_pass_end, !r_restart)

    // a restart request on any other item leaves the flag set
    `PVS_ASSERT_NEXT(a_restart_sets, i_clk, i_rst_n, w_restart_req && !w_pass_end, r_restart)

    // a finished item waits while the output register is still held
    `PVS_ASSERT_NEXT(a_out_holds, i_clk, i_rst_n, w_out_blocked, r_state == S_OUT)

endmodule

`default_nettype wire
